// ----- src/vec2_arith_unit_assert.svh -----
// ---------------------------------------------------------------------------
// vec2_arith_unit_assert.svh: assertion macros for the vector arithmetic unit
// Concurrent checks on clk with rst as the disable condition. They collapse
// to nothing when the design is built for synthesis.
// ---------------------------------------------------------------------------
`ifndef VEC2_ARITH_UNIT_ASSERT_SVH
`define VEC2_ARITH_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define VAU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vec2_arith_unit assertion failed");
// Next-cycle implication.
`define VAU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vec2_arith_unit assertion failed");
`else
`define VAU_ASSERT_IMP(label, ante, cons)
`define VAU_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- src/vau_pkg.sv -----
// ---------------------------------------------------------------------------
// vau_pkg: shared types and constants of the vector arithmetic unit
// Opcodes, operation classes, queue entry layout, sequencer states and the
// saturating clamp used on most result components.
// ---------------------------------------------------------------------------
package vau_pkg;

  // Number format: signed fixed point with FRAC_BITS fraction bits.
  localparam int FRAC_BITS  = 16;
  localparam int DW         = 32;
  localparam int WIDE_W     = 2 * DW + 1;
  localparam int NUM_W      = DW + FRAC_BITS;
  localparam int DIV_STEPS  = NUM_W;
  localparam int ROOT_STEPS = DW;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  // Command queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam logic [QPTR_W:0] Q_FULL = (QPTR_W + 1)'(QDEPTH);

  localparam logic [DW-2:0] EPS_RESET = 31'd66;
  localparam logic [DW-1:0] Q_MAX = {1'b0, {(DW - 1){1'b1}}};
  localparam logic [DW-1:0] Q_MIN = {1'b1, {(DW - 1){1'b0}}};

  typedef enum logic [3:0] {
    CMD_ADD    = 4'd0,
    CMD_SUB    = 4'd1,
    CMD_MUL    = 4'd2,
    CMD_DIV    = 4'd3,
    CMD_SCALE  = 4'd4,
    CMD_DOT    = 4'd5,
    CMD_CROSS  = 4'd6,
    CMD_DISTSQ = 4'd7,
    CMD_MAG    = 4'd8,
    CMD_NORMAL = 4'd9
  } cmd_t;

  // Class of work that the back end has to do for a command.
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_ADDSUB,
    KIND_PROD,
    KIND_DIV,
    KIND_ROOT
  } kind_t;

  typedef struct packed {
    logic [3:0]             cmd;
    kind_t                  kind;
    logic signed [DW-1:0]   a_x;
    logic signed [DW-1:0]   a_y;
    logic signed [DW-1:0]   b_x;
    logic signed [DW-1:0]   b_y;
    logic signed [DW-1:0]   factor;
  } entry_t;

  // Head of the command queue as seen by the back end.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL0,
    ST_MUL1,
    ST_COMB,
    ST_SCAL,
    ST_ROOT,
    ST_REND,
    ST_DSET,
    ST_DIV,
    ST_DEND,
    ST_FIN
  } state_t;

  // Clamp a wide signed value to the DW-bit range; the top bit flags a clamp.
  function automatic logic [DW:0] clamp_q(input logic signed [WIDE_W-1:0] v);
    logic [DW:0] r;
    if (!v[WIDE_W-1] && (|v[WIDE_W-2:DW-1])) begin
      r = {1'b1, Q_MAX};
    end else if (v[WIDE_W-1] && !(&v[WIDE_W-2:DW-1])) begin
      r = {1'b1, Q_MIN};
    end else begin
      r = {1'b0, v[DW-1:0]};
    end
    return r;
  endfunction

endpackage

// ----- src/vau_front.sv -----
// ---------------------------------------------------------------------------
// vau_front: input acceptance, classification and command queue
// Takes one transaction per cycle while the queue has room, tags it with the
// class of work it needs and hands the oldest entry to the back end.
// ---------------------------------------------------------------------------
module vau_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [5*vau_pkg::DW-1:0]          s_tdata,
  input  logic [3:0]                        s_tuser,
  output vau_pkg::head_t                    head,
  input  logic                              pop
);

  localparam int DW = vau_pkg::DW;

  vau_pkg::entry_t                  queue_mem [vau_pkg::QDEPTH];
  logic [vau_pkg::QPTR_W-1:0]       wr_ptr;
  logic [vau_pkg::QPTR_W-1:0]       rd_ptr;
  logic [vau_pkg::QPTR_W:0]         count;
  vau_pkg::entry_t                  new_entry;
  logic                             push;
  logic                             do_pop;

  assign s_tready = (count != vau_pkg::Q_FULL);
  assign push     = s_tvalid && s_tready;
  assign do_pop   = pop && (count != '0);

  // Unpack the transaction and classify its opcode.
  always_comb begin
    new_entry.cmd    = s_tuser;
    new_entry.a_x    = s_tdata[DW-1:0];
    new_entry.a_y    = s_tdata[2*DW-1:DW];
    new_entry.b_x    = s_tdata[3*DW-1:2*DW];
    new_entry.b_y    = s_tdata[4*DW-1:3*DW];
    new_entry.factor = s_tdata[5*DW-1:4*DW];
    case (vau_pkg::cmd_t'(s_tuser))
      vau_pkg::CMD_ADD, vau_pkg::CMD_SUB: begin
        new_entry.kind = vau_pkg::KIND_ADDSUB;
      end
      vau_pkg::CMD_MUL, vau_pkg::CMD_SCALE, vau_pkg::CMD_DOT,
      vau_pkg::CMD_CROSS, vau_pkg::CMD_DISTSQ: begin
        new_entry.kind = vau_pkg::KIND_PROD;
      end
      vau_pkg::CMD_DIV: begin
        new_entry.kind = vau_pkg::KIND_DIV;
      end
      vau_pkg::CMD_MAG, vau_pkg::CMD_NORMAL: begin
        new_entry.kind = vau_pkg::KIND_ROOT;
      end
      default: begin
        new_entry.kind = vau_pkg::KIND_NONE;
      end
    endcase
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      queue_mem[wr_ptr] <= new_entry;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head.valid = (count != '0);
  assign head.entry = queue_mem[rd_ptr];

endmodule

// ----- src/vau_back.sv -----
// ---------------------------------------------------------------------------
// vau_back: execution sequencer of the vector arithmetic unit
// One shared multiplier, a bit-pair square root and a one-bit-per-cycle
// divider, stepped by a sequencer, with a registered result stage.
// ---------------------------------------------------------------------------
module vau_back (
  input  logic                          clk,
  input  logic                          rst,
  input  vau_pkg::head_t                head,
  output logic                          pop,
  input  logic [vau_pkg::DW-2:0]        eps,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [3*vau_pkg::DW-1:0]      m_tdata,
  output logic [1:0]                    m_tuser
);

  localparam int DW     = vau_pkg::DW;
  localparam int FB     = vau_pkg::FRAC_BITS;
  localparam int WW     = vau_pkg::WIDE_W;
  localparam int NW     = vau_pkg::NUM_W;
  localparam int CW     = vau_pkg::CNT_W;

  vau_pkg::state_t        state;
  vau_pkg::state_t        state_next;
  logic                   out_load;

  vau_pkg::entry_t        cur;
  logic signed [DW:0]     opa0, opb0, opa1, opb1;
  logic signed [2*DW-1:0] p0, p1;
  logic signed [WW-1:0]   acc;
  logic [DW-1:0]          rx, ry, rs;
  logic                   dz, sat;
  logic                   comp;
  logic [CW-1:0]          cnt;

  logic [DW-1:0]          root;
  logic [DW:0]            rt_rem;
  logic [2*DW-1:0]        rt_num;

  logic [NW-1:0]          dv_num;
  logic [DW-1:0]          dv_rem;
  logic [DW-1:0]          dv_den;
  logic                   dv_neg;

  // Datapath intermediates.
  logic signed [DW:0]     sum_x, sum_y, dif_x, dif_y;
  logic                   dx_bad, dy_bad;
  logic signed [DW:0]     mag_dx, mag_dy, mag_ax, mag_ay;
  logic [DW:0]            clx, cly, cls;
  logic [DW:0]            cl0, cl1;
  logic signed [DW:0]     mul_a, mul_b;
  logic signed [2*DW+1:0] prod;
  logic signed [WW-1:0]   sh0, sh1, acc_calc, acc_sh;
  logic [DW+2:0]          rt_shift, rt_trial, rt_diff;
  logic                   rt_ge;
  logic [DW:0]            dv_shift, dv_diff;
  logic                   dv_ge;
  logic signed [NW:0]     dv_q, dv_res;
  logic [DW:0]            dv_cl;
  logic signed [DW-1:0]   num_a, den_b;
  logic [DW-1:0]          num_mag, den_mag;
  logic                   den_zero;
  logic                   norm_ok;

  // Element-wise sums and differences of the two vectors.
  always_comb begin
    if (cur.cmd == vau_pkg::CMD_SUB) begin
      sum_x = {cur.a_x[DW-1], cur.a_x} - {cur.b_x[DW-1], cur.b_x};
      sum_y = {cur.a_y[DW-1], cur.a_y} - {cur.b_y[DW-1], cur.b_y};
    end else begin
      sum_x = {cur.a_x[DW-1], cur.a_x} + {cur.b_x[DW-1], cur.b_x};
      sum_y = {cur.a_y[DW-1], cur.a_y} + {cur.b_y[DW-1], cur.b_y};
    end
    dif_x  = {cur.a_x[DW-1], cur.a_x} - {cur.b_x[DW-1], cur.b_x};
    dif_y  = {cur.a_y[DW-1], cur.a_y} - {cur.b_y[DW-1], cur.b_y};
    clx    = vau_pkg::clamp_q({{(WW-DW-1){sum_x[DW]}}, sum_x});
    cly    = vau_pkg::clamp_q({{(WW-DW-1){sum_y[DW]}}, sum_y});
    // A distance component of magnitude 2^31 or more saturates the result.
    dx_bad = (dif_x[DW] != dif_x[DW-1]) ||
             (dif_x[DW] && (dif_x[DW-1:0] == vau_pkg::Q_MIN));
    dy_bad = (dif_y[DW] != dif_y[DW-1]) ||
             (dif_y[DW] && (dif_y[DW-1:0] == vau_pkg::Q_MIN));
    mag_dx = dif_x[DW] ? -dif_x : dif_x;
    mag_dy = dif_y[DW] ? -dif_y : dif_y;
    mag_ax = cur.a_x[DW-1] ? -{cur.a_x[DW-1], cur.a_x} : {cur.a_x[DW-1], cur.a_x};
    mag_ay = cur.a_y[DW-1] ? -{cur.a_y[DW-1], cur.a_y} : {cur.a_y[DW-1], cur.a_y};
  end

  // Shared multiplier and the combination of its two products.
  always_comb begin
    mul_a    = (state == vau_pkg::ST_MUL0) ? opa0 : opa1;
    mul_b    = (state == vau_pkg::ST_MUL0) ? opb0 : opb1;
    prod     = mul_a * mul_b;
    sh0      = $signed({p0[2*DW-1], p0}) >>> FB;
    sh1      = $signed({p1[2*DW-1], p1}) >>> FB;
    cl0      = vau_pkg::clamp_q(sh0);
    cl1      = vau_pkg::clamp_q(sh1);
    if (cur.cmd == vau_pkg::CMD_CROSS) begin
      acc_calc = $signed({p0[2*DW-1], p0}) - $signed({p1[2*DW-1], p1});
    end else begin
      acc_calc = $signed({p0[2*DW-1], p0}) + $signed({p1[2*DW-1], p1});
    end
    acc_sh   = acc >>> FB;
    cls      = vau_pkg::clamp_q(acc_sh);
  end

  // One bit pair of the square root per cycle.
  always_comb begin
    rt_shift = {rt_rem, rt_num[2*DW-1 -: 2]};
    rt_trial = {1'b0, root, 2'b01};
    rt_ge    = (rt_shift >= rt_trial);
    rt_diff  = rt_shift - rt_trial;
    norm_ok  = (root != '0) && (root >= {1'b0, eps});
  end

  // One quotient bit per cycle, then the floor correction and clamp.
  always_comb begin
    dv_shift = {dv_rem, dv_num[NW-1]};
    dv_ge    = (dv_shift >= {1'b0, dv_den});
    dv_diff  = dv_shift - {1'b0, dv_den};
    dv_q     = {1'b0, dv_num};
    if (!dv_neg) begin
      dv_res = dv_q;
    end else if (|dv_rem) begin
      dv_res = ~dv_q;
    end else begin
      dv_res = -dv_q;
    end
    dv_cl    = vau_pkg::clamp_q({{(WW-NW-1){dv_res[NW]}}, dv_res});
  end

  // Operand selection for the component being divided.
  always_comb begin
    num_a    = comp ? cur.a_y : cur.a_x;
    den_b    = comp ? cur.b_y : cur.b_x;
    num_mag  = num_a[DW-1] ? (~num_a + 1'b1) : num_a;
    den_zero = (den_b == '0);
    if (cur.cmd == vau_pkg::CMD_DIV) begin
      den_mag = den_b[DW-1] ? (~den_b + 1'b1) : den_b;
    end else begin
      den_mag = root;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vau_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, queue pop and result load.
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    out_load   = 1'b0;
    case (state)
      vau_pkg::ST_IDLE: begin
        if (head.valid) begin
          pop        = 1'b1;
          state_next = vau_pkg::ST_PREP;
        end
      end
      vau_pkg::ST_PREP: begin
        case (cur.kind)
          vau_pkg::KIND_PROD: begin
            if ((cur.cmd == vau_pkg::CMD_DISTSQ) && (dx_bad || dy_bad)) begin
              state_next = vau_pkg::ST_FIN;
            end else begin
              state_next = vau_pkg::ST_MUL0;
            end
          end
          vau_pkg::KIND_ROOT: state_next = vau_pkg::ST_MUL0;
          vau_pkg::KIND_DIV:  state_next = vau_pkg::ST_DSET;
          default:            state_next = vau_pkg::ST_FIN;
        endcase
      end
      vau_pkg::ST_MUL0: state_next = vau_pkg::ST_MUL1;
      vau_pkg::ST_MUL1: state_next = vau_pkg::ST_COMB;
      vau_pkg::ST_COMB: begin
        if (cur.kind == vau_pkg::KIND_ROOT) begin
          state_next = vau_pkg::ST_ROOT;
        end else if ((cur.cmd == vau_pkg::CMD_MUL) ||
                     (cur.cmd == vau_pkg::CMD_SCALE)) begin
          state_next = vau_pkg::ST_FIN;
        end else begin
          state_next = vau_pkg::ST_SCAL;
        end
      end
      vau_pkg::ST_SCAL: state_next = vau_pkg::ST_FIN;
      vau_pkg::ST_ROOT: begin
        if (cnt == '0) begin
          state_next = vau_pkg::ST_REND;
        end
      end
      vau_pkg::ST_REND: begin
        if ((cur.cmd == vau_pkg::CMD_NORMAL) && norm_ok) begin
          state_next = vau_pkg::ST_DSET;
        end else begin
          state_next = vau_pkg::ST_FIN;
        end
      end
      vau_pkg::ST_DSET: begin
        if ((cur.cmd == vau_pkg::CMD_DIV) && den_zero) begin
          if (comp) begin
            state_next = vau_pkg::ST_FIN;
          end
        end else begin
          state_next = vau_pkg::ST_DIV;
        end
      end
      vau_pkg::ST_DIV: begin
        if (cnt == '0) begin
          state_next = vau_pkg::ST_DEND;
        end
      end
      vau_pkg::ST_DEND: begin
        state_next = comp ? vau_pkg::ST_FIN : vau_pkg::ST_DSET;
      end
      vau_pkg::ST_FIN: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = vau_pkg::ST_IDLE;
        end
      end
      default: state_next = vau_pkg::ST_IDLE;
    endcase
  end

  // Working registers, stepped by the sequencer.
  always_ff @(posedge clk) begin
    case (state)
      vau_pkg::ST_IDLE: begin
        cur  <= head.entry;
        rx   <= '0;
        ry   <= '0;
        rs   <= '0;
        dz   <= 1'b0;
        sat  <= 1'b0;
        comp <= 1'b0;
      end
      vau_pkg::ST_PREP: begin
        case (vau_pkg::cmd_t'(cur.cmd))
          vau_pkg::CMD_ADD, vau_pkg::CMD_SUB: begin
            rx  <= clx[DW-1:0];
            ry  <= cly[DW-1:0];
            sat <= clx[DW] | cly[DW];
          end
          vau_pkg::CMD_MUL, vau_pkg::CMD_DOT: begin
            opa0 <= {cur.a_x[DW-1], cur.a_x};
            opb0 <= {cur.b_x[DW-1], cur.b_x};
            opa1 <= {cur.a_y[DW-1], cur.a_y};
            opb1 <= {cur.b_y[DW-1], cur.b_y};
          end
          vau_pkg::CMD_SCALE: begin
            opa0 <= {cur.a_x[DW-1], cur.a_x};
            opb0 <= {cur.factor[DW-1], cur.factor};
            opa1 <= {cur.a_y[DW-1], cur.a_y};
            opb1 <= {cur.factor[DW-1], cur.factor};
          end
          vau_pkg::CMD_CROSS: begin
            opa0 <= {cur.a_x[DW-1], cur.a_x};
            opb0 <= {cur.b_y[DW-1], cur.b_y};
            opa1 <= {cur.a_y[DW-1], cur.a_y};
            opb1 <= {cur.b_x[DW-1], cur.b_x};
          end
          vau_pkg::CMD_DISTSQ: begin
            if (dx_bad || dy_bad) begin
              rs  <= vau_pkg::Q_MAX;
              sat <= 1'b1;
            end
            opa0 <= mag_dx;
            opb0 <= mag_dx;
            opa1 <= mag_dy;
            opb1 <= mag_dy;
          end
          vau_pkg::CMD_MAG, vau_pkg::CMD_NORMAL: begin
            opa0 <= mag_ax;
            opb0 <= mag_ax;
            opa1 <= mag_ay;
            opb1 <= mag_ay;
          end
          default: begin
            comp <= 1'b0;
          end
        endcase
      end
      vau_pkg::ST_MUL0: p0 <= prod[2*DW-1:0];
      vau_pkg::ST_MUL1: p1 <= prod[2*DW-1:0];
      vau_pkg::ST_COMB: begin
        acc <= acc_calc;
        if ((cur.cmd == vau_pkg::CMD_MUL) || (cur.cmd == vau_pkg::CMD_SCALE)) begin
          rx  <= cl0[DW-1:0];
          ry  <= cl1[DW-1:0];
          sat <= cl0[DW] | cl1[DW];
        end
        // Square root set-up for the magnitude commands.
        rt_num <= acc_calc[2*DW-1:0];
        rt_rem <= '0;
        root   <= '0;
        cnt    <= CW'(vau_pkg::ROOT_STEPS - 1);
      end
      vau_pkg::ST_SCAL: begin
        rs  <= cls[DW-1:0];
        sat <= sat | cls[DW];
      end
      vau_pkg::ST_ROOT: begin
        rt_num <= rt_num << 2;
        if (rt_ge) begin
          rt_rem <= rt_diff[DW:0];
          root   <= {root[DW-2:0], 1'b1};
        end else begin
          rt_rem <= rt_shift[DW:0];
          root   <= {root[DW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
      end
      vau_pkg::ST_REND: begin
        if (cur.cmd == vau_pkg::CMD_MAG) begin
          if (root[DW-1]) begin
            rs  <= vau_pkg::Q_MAX;
            sat <= 1'b1;
          end else begin
            rs  <= root;
          end
        end
        comp <= 1'b0;
      end
      vau_pkg::ST_DSET: begin
        if ((cur.cmd == vau_pkg::CMD_DIV) && den_zero) begin
          // Zero divisor: clamp the component by the sign of the dividend.
          dz <= 1'b1;
          if (comp) begin
            ry <= num_a[DW-1] ? vau_pkg::Q_MIN : vau_pkg::Q_MAX;
          end else begin
            rx <= num_a[DW-1] ? vau_pkg::Q_MIN : vau_pkg::Q_MAX;
          end
          comp <= 1'b1;
        end else begin
          dv_num <= {num_mag, {FB{1'b0}}};
          dv_rem <= '0;
          dv_den <= den_mag;
          dv_neg <= num_a[DW-1] ^ ((cur.cmd == vau_pkg::CMD_DIV) && den_b[DW-1]);
          cnt    <= CW'(vau_pkg::DIV_STEPS - 1);
        end
      end
      vau_pkg::ST_DIV: begin
        dv_num <= {dv_num[NW-2:0], dv_ge};
        dv_rem <= dv_ge ? dv_diff[DW-1:0] : dv_shift[DW-1:0];
        cnt    <= cnt - 1'b1;
      end
      vau_pkg::ST_DEND: begin
        if (comp) begin
          ry <= dv_cl[DW-1:0];
        end else begin
          rx <= dv_cl[DW-1:0];
        end
        sat  <= sat | dv_cl[DW];
        comp <= 1'b1;
      end
      default: begin
        comp <= comp;
      end
    endcase
  end

  // Result register: a finished transaction waits here for the sink.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {rs, ry, rx};
      m_tuser <= {sat, dz};
    end
  end

endmodule

// ----- src/vec2_arith_unit.sv -----
// ---------------------------------------------------------------------------
// vec2_arith_unit: 2D vector arithmetic unit in signed Q16.16 fixed point
//
//  channel   dir  handshake          payload
//  s_axis    in   s_tvalid/s_tready  s_tdata: a_x,a_y,b_x,b_y,factor; s_tuser: cmd
//  m_axis    out  m_tvalid/m_tready  m_tdata: res_x,res_y,res_scalar;
//                                    m_tuser: div_zero,saturated
//  cfg       in   cfg_wen            cfg_wdata: epsilon
//
// Input transactions are taken one per cycle, while the four-entry queue has room.
// The back end executes one transaction at a time; its execution time is set by
// the shared multiplier, the 32-step square root and the 48-step divider.
// Reset is synchronous and clears the queue, the sequencer and epsilon (66).
// Either side may stall freely; the result register holds until taken.
// ---------------------------------------------------------------------------
`include "vec2_arith_unit_assert.svh"

module vec2_arith_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // a_x [31:0], a_y [63:32], b_x [95:64], b_y [127:96], factor [159:128]
  input  logic [5*vau_pkg::DW-1:0]     s_tdata,
  // cmd [3:0]
  input  logic [3:0]                   s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // res_x [31:0], res_y [63:32], res_scalar [95:64]
  output logic [3*vau_pkg::DW-1:0]     m_tdata,
  // div_zero [0], saturated [1]
  output logic [1:0]                   m_tuser,
  input  logic                         cfg_wen,
  input  logic [vau_pkg::DW-2:0]       cfg_wdata
);

  logic [vau_pkg::DW-2:0] eps;
  vau_pkg::head_t         front_head;
  logic                   back_pop;

  // Normalise threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= vau_pkg::EPS_RESET;
    end else if (cfg_wen) begin
      eps <= cfg_wdata;
    end
  end

  // Front: acceptance, classification and queue.
  vau_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .head     (front_head),
    .pop      (back_pop)
  );

  // Back: execution and result register.
  vau_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (front_head),
    .pop      (back_pop),
    .eps      (eps),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // The back end only takes an entry that the queue holds.
  `VAU_ASSERT_IMP(a_pop_nonempty, back_pop, front_head.valid)
  // A full queue stays full until the back end takes an entry.
  `VAU_ASSERT_NXT(a_full_holds, !s_tready && !back_pop, !s_tready)
  // A divide-by-zero result is a vector result, so its scalar is zero.
  `VAU_ASSERT_IMP(a_dz_vector, m_tvalid && m_tuser[0], m_tdata[95:64] == 32'd0)

endmodule
